>>> sv/ppq_pkg.sv
// Package for the process priority queue: depth constants, entry and
// transfer structs, command and status codes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package ppq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_POP    = 2'd2,
        CMD_REMOVE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRD,
        S_SCMP,
        S_IMRD,
        S_IMWR,
        S_PUT,
        S_RMRD,
        S_RMWR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] process_id;
        logic [7:0] priority_level;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] removed_id;
        logic [7:0] removed_priority;
        logic [4:0] entry_count;
    } t_out_item;

    typedef struct packed {
        logic [7:0] id;
        logic [7:0] pri;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

>>> sv/ppq_mem.sv
// Entry store of the queue: one write port, one read port with
// registered read data. Depends on ppq_pkg.
`timescale 1ns / 1ps

module ppq_mem (
    input  logic              i_clk,
    input  ppq_pkg::t_mem_req i_req,
    output ppq_pkg::t_entry   o_rdata
);

    ppq_pkg::t_entry r_mem [ppq_pkg::QUEUE_DEPTH];
    ppq_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/ppq_ctrl.sv
// Sequencer of the queue: scans entries one at a time through the shared
// compare, then moves entries one place per read/write pair.
// Depends on ppq_pkg.
`timescale 1ns / 1ps

module ppq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ppq_pkg::t_in_item   i_in_data,
    output logic                o_busy,
    output ppq_pkg::t_mem_req   o_mem_req,
    input  ppq_pkg::t_entry     i_rdata,
    output logic                o_res_valid,
    output ppq_pkg::t_out_item  o_res,
    input  logic                i_res_take
);

    ppq_pkg::t_state    r_state, n_state;
    ppq_pkg::t_cmd      r_cmd, n_cmd;
    logic [7:0]         r_id, n_id;
    logic [7:0]         r_pri, n_pri;
    logic [ppq_pkg::CNT_W-1:0] r_pos, n_pos;
    logic [ppq_pkg::CNT_W-1:0] r_mv, n_mv;
    logic [ppq_pkg::CNT_W-1:0] r_count, n_count;
    ppq_pkg::t_out_item r_res, n_res;

    logic [ppq_pkg::CNT_W-1:0] mv_inc, mv_dec, pos_inc, cnt_inc, cnt_dec;
    logic                      hit;
    logic                      full;
    ppq_pkg::t_cmd             in_cmd;

    assign mv_inc  = r_mv + 1'b1;
    assign mv_dec  = r_mv - 1'b1;
    assign pos_inc = r_pos + 1'b1;
    assign cnt_inc = r_count + 1'b1;
    assign cnt_dec = r_count - 1'b1;
    assign full    = (r_count == ppq_pkg::CNT_W'(ppq_pkg::QUEUE_DEPTH));
    assign in_cmd  = ppq_pkg::t_cmd'(i_in_data.command);

    always_comb begin
        unique case (r_cmd)
            ppq_pkg::CMD_INSERT: hit = (i_rdata.pri < r_pri);
            ppq_pkg::CMD_REMOVE: hit = (i_rdata.id == r_id);
            ppq_pkg::CMD_POP:    hit = 1'b1;
            default:             hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppq_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_cmd <= n_cmd;
        r_id  <= n_id;
        r_pri <= n_pri;
        r_pos <= n_pos;
        r_mv  <= n_mv;
        r_res <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_id    = r_id;
        n_pri   = r_pri;
        n_pos   = r_pos;
        n_mv    = r_mv;
        n_count = r_count;
        n_res   = r_res;
        o_mem_req       = '0;
        o_mem_req.raddr = r_pos[ppq_pkg::ADDR_W-1:0];

        unique case (r_state)
            ppq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = in_cmd;
                    n_id  = i_in_data.process_id;
                    n_pri = i_in_data.priority_level;
                    n_pos = '0;
                    n_res = '0;
                    if ((in_cmd == ppq_pkg::CMD_INSERT || in_cmd == ppq_pkg::CMD_APPEND)
                        && full) begin
                        n_res.status      = ppq_pkg::ST_FULL;
                        n_res.entry_count = 5'(r_count);
                        n_state           = ppq_pkg::S_DONE;
                    end else if (in_cmd == ppq_pkg::CMD_APPEND) begin
                        n_pos   = r_count;
                        n_mv    = r_count;
                        n_state = ppq_pkg::S_IMRD;
                    end else begin
                        n_state = ppq_pkg::S_SRD;
                    end
                end
            end
            ppq_pkg::S_SRD: begin
                if (r_pos == r_count) begin
                    if (r_cmd == ppq_pkg::CMD_INSERT) begin
                        n_mv    = r_count;
                        n_state = ppq_pkg::S_IMRD;
                    end else begin
                        n_res.status      = ppq_pkg::ST_MISS;
                        n_res.entry_count = 5'(r_count);
                        n_state           = ppq_pkg::S_DONE;
                    end
                end else begin
                    n_state = ppq_pkg::S_SCMP;
                end
            end
            ppq_pkg::S_SCMP: begin
                if (hit) begin
                    if (r_cmd == ppq_pkg::CMD_INSERT) begin
                        n_mv    = r_count;
                        n_state = ppq_pkg::S_IMRD;
                    end else begin
                        n_res.removed_id       = i_rdata.id;
                        n_res.removed_priority = i_rdata.pri;
                        n_mv                   = r_pos;
                        n_state                = ppq_pkg::S_RMRD;
                    end
                end else begin
                    n_pos   = pos_inc;
                    n_state = ppq_pkg::S_SRD;
                end
            end
            ppq_pkg::S_IMRD: begin
                if (r_mv == r_pos) begin
                    n_state = ppq_pkg::S_PUT;
                end else begin
                    o_mem_req.raddr = mv_dec[ppq_pkg::ADDR_W-1:0];
                    n_state         = ppq_pkg::S_IMWR;
                end
            end
            ppq_pkg::S_IMWR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_mv[ppq_pkg::ADDR_W-1:0];
                o_mem_req.wdata = i_rdata;
                n_mv            = mv_dec;
                n_state         = ppq_pkg::S_IMRD;
            end
            ppq_pkg::S_PUT: begin
                o_mem_req.we        = 1'b1;
                o_mem_req.waddr     = r_pos[ppq_pkg::ADDR_W-1:0];
                o_mem_req.wdata.id  = r_id;
                o_mem_req.wdata.pri = r_pri;
                n_count             = cnt_inc;
                n_res.status        = ppq_pkg::ST_OK;
                n_res.entry_count   = 5'(cnt_inc);
                n_state             = ppq_pkg::S_DONE;
            end
            ppq_pkg::S_RMRD: begin
                if (mv_inc == r_count) begin
                    n_count           = cnt_dec;
                    n_res.status      = ppq_pkg::ST_OK;
                    n_res.entry_count = 5'(cnt_dec);
                    n_state           = ppq_pkg::S_DONE;
                end else begin
                    o_mem_req.raddr = mv_inc[ppq_pkg::ADDR_W-1:0];
                    n_state         = ppq_pkg::S_RMWR;
                end
            end
            ppq_pkg::S_RMWR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_mv[ppq_pkg::ADDR_W-1:0];
                o_mem_req.wdata = i_rdata;
                n_mv            = mv_inc;
                n_state         = ppq_pkg::S_RMRD;
            end
            ppq_pkg::S_DONE: begin
                if (i_res_take) begin
                    n_state = ppq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ppq_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != ppq_pkg::S_IDLE);
    assign o_res_valid = (r_state == ppq_pkg::S_DONE);
    assign o_res       = r_res;

endmodule

>>> sv/process_priority_queue.sv
// Process priority queue, one command at a time. A command examines entries, shifts
// entries, then checks, writes and loads the output register; an insert or append on
// a full queue is rejected without touching the entries. The next command is taken
// in the cycle after the result leaves the sequencer, and no new command is taken
// before that. Synchronous active-low reset empties the queue; no clearing pass is needed.
`timescale 1ns / 1ps

module process_priority_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ppq_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ppq_pkg::t_out_item  o_out_data
);

    ppq_pkg::t_mem_req  mem_req;
    ppq_pkg::t_entry    mem_rdata;
    logic               busy;
    logic               res_valid;
    ppq_pkg::t_out_item res;
    logic               res_take;

    logic               r_out_valid;
    ppq_pkg::t_out_item r_out_data;

    ppq_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    ppq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_busy      (busy),
        .o_mem_req   (mem_req),
        .i_rdata     (mem_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_take) begin
            r_out_data <= res;
        end
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
